[rtl/core/ipv4_udp_receive_filter_assert.svh]
// Assertion macros shared by the receive filter modules.
`ifndef IPV4_UDP_RECEIVE_FILTER_ASSERT_SVH
`define IPV4_UDP_RECEIVE_FILTER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define IURF_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IURF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/iurf_pkg.sv]
// Types and constants of the IPv4/UDP receive filter.
`default_nettype none

package iurf_pkg;

    localparam logic [15:0] HEADER_BYTES    = 16'd28;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] BYTE_COUNT_MAX  = 16'hFFFF;

    // Header byte offsets within the frame
    localparam logic [15:0] POS_TOTLEN_HI   = 16'd2;
    localparam logic [15:0] POS_TOTLEN_LO   = 16'd3;
    localparam logic [15:0] POS_PROTOCOL    = 16'd9;
    localparam logic [15:0] POS_SRC_ADDR0   = 16'd12;
    localparam logic [15:0] POS_SRC_ADDR1   = 16'd13;
    localparam logic [15:0] POS_SRC_ADDR2   = 16'd14;
    localparam logic [15:0] POS_SRC_ADDR3   = 16'd15;
    localparam logic [15:0] POS_SRC_PORT_HI = 16'd20;
    localparam logic [15:0] POS_SRC_PORT_LO = 16'd21;
    localparam logic [15:0] POS_DST_PORT_HI = 16'd22;
    localparam logic [15:0] POS_DST_PORT_LO = 16'd23;

    localparam logic [31:0] SRC_ADDR_RESET  = 32'h7F00_0001;
    localparam logic [15:0] SRC_PORT_RESET  = 16'd9090;
    localparam logic [15:0] DST_PORT_RESET  = 16'd0;

    typedef enum logic [1:0] {
        CFG_SRC_ADDR = 2'd0,
        CFG_SRC_PORT = 2'd1,
        CFG_DST_PORT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        RC_OK       = 3'd0,
        RC_SHORT    = 3'd1,
        RC_NOT_UDP  = 3'd2,
        RC_SRC_ADDR = 3'd3,
        RC_LENGTH   = 3'd4,
        RC_DST_PORT = 3'd5,
        RC_SRC_PORT = 3'd6
    } reject_code_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } filter_cfg_t;

    // Frame state as it stands after the byte now being taken
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] declared_length;
        logic        proto_ok;
        logic        src_addr_ok;
        logic        dst_port_ok;
        logic        src_port_ok;
    } frame_status_t;

    // Result beat layout, accepted in the lowest bit
    typedef struct packed {
        reject_code_t reject_code;
        logic [15:0]  payload_length;
        logic         accepted;
    } filter_result_t;

endpackage

`default_nettype wire

[rtl/core/ipv4_udp_receive_filter.sv]
// IPv4/UDP receive header filter: top level.
//
// Usage:
//   s_* channel carries a received IPv4 frame one byte per beat in wire
//   order (s_tdata[7:0]); s_tlast marks the final byte. The IP header is a
//   fixed 20 bytes followed by the 8-byte UDP header.
//   m_* channel carries one result beat per frame, sent after the last byte:
//   accepted flag, payload length (bytes - 28, 0 on reject), reject code.
//   cfg_* channel writes the expected source address (index 0), source
//   port (index 1) and destination port (index 2); cfg_ready is always high.
// Result path: the last byte waits in the input register until the result
//   register is free; its verdict then enters the result register and
//   m_tvalid rises.
// Throughput: one byte per cycle unless a last byte waits on the result;
//   set by the combinational header update from input to result register.
// Reset: aresetn low clears the byte count, the header checks and both
//   valid flags, and loads the register reset values (127.0.0.1, port 9090,
//   port 0).
// Stall: while a result waits on m_tready, payload bytes keep flowing; only
//   the next frame's last byte is held in the input register.
`default_nettype none

module ipv4_udp_receive_filter
    import iurf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Frame byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  wire logic        s_tlast,   // last_byte
    // Verdict output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] accepted, [16:1] payload_length,
                                        // [19:17] reject_code, [23:20] zero
    // Register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Input register stage
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;
    logic           advance;

    filter_cfg_t    cfg_reg;
    frame_status_t  status;
    filter_result_t result;

    // Non-last bytes never produce a result, so they always advance;
    // a last byte waits only for the result register to free up.
    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold payload while the stage is stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Configuration registers; writes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_addr <= SRC_ADDR_RESET;
            cfg_reg.src_port <= SRC_PORT_RESET;
            cfg_reg.dst_port <= DST_PORT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_SRC_ADDR: cfg_reg.src_addr <= cfg_data;
                CFG_SRC_PORT: cfg_reg.src_port <= cfg_data[15:0];
                CFG_DST_PORT: cfg_reg.dst_port <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    iurf_hdr_track u_hdr_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .consume    (advance),
        .frame_byte (in_byte_reg),
        .last_byte  (in_last_reg),
        .cfg        (cfg_reg),
        .status     (status)
    );

    iurf_verdict u_verdict (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_done (advance && in_last_reg),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_result   (result)
    );

    assign m_tdata = {4'b0000, result};

endmodule

`default_nettype wire

[rtl/core/iurf_hdr_track.sv]
// Per-frame byte counter and header field checks.
`default_nettype none

module iurf_hdr_track
    import iurf_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          consume,
    input  wire logic [7:0]    frame_byte,
    input  wire logic          last_byte,
    input  wire filter_cfg_t   cfg,
    output frame_status_t      status
);

    logic [15:0] pos_reg,  pos_next;
    logic [15:0] decl_reg, decl_next;
    logic        proto_reg, proto_next;
    logic        saddr_reg, saddr_next;
    logic        dport_reg, dport_next;
    logic        sport_reg, sport_next;

    always_comb begin
        pos_next   = (pos_reg == BYTE_COUNT_MAX) ? pos_reg : pos_reg + 16'd1;
        decl_next  = decl_reg;
        proto_next = proto_reg;
        saddr_next = saddr_reg;
        dport_next = dport_reg;
        sport_next = sport_reg;
        case (pos_reg)
            POS_TOTLEN_HI:   decl_next  = {frame_byte, 8'h00};
            POS_TOTLEN_LO:   decl_next  = decl_reg | {8'h00, frame_byte};
            POS_PROTOCOL:    proto_next = (frame_byte == PROTO_UDP);
            POS_SRC_ADDR0:   if (frame_byte != cfg.src_addr[31:24]) saddr_next = 1'b0;
            POS_SRC_ADDR1:   if (frame_byte != cfg.src_addr[23:16]) saddr_next = 1'b0;
            POS_SRC_ADDR2:   if (frame_byte != cfg.src_addr[15:8])  saddr_next = 1'b0;
            POS_SRC_ADDR3:   if (frame_byte != cfg.src_addr[7:0])   saddr_next = 1'b0;
            POS_SRC_PORT_HI: if (frame_byte != cfg.src_port[15:8])  sport_next = 1'b0;
            POS_SRC_PORT_LO: if (frame_byte != cfg.src_port[7:0])   sport_next = 1'b0;
            POS_DST_PORT_HI: if (frame_byte != cfg.dst_port[15:8])  dport_next = 1'b0;
            POS_DST_PORT_LO: if (frame_byte != cfg.dst_port[7:0])   dport_next = 1'b0;
            default: ;
        endcase

        status.frame_length    = pos_next;
        status.declared_length = decl_next;
        status.proto_ok        = proto_next;
        status.src_addr_ok     = saddr_next;
        status.dst_port_ok     = dport_next;
        status.src_port_ok     = sport_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && last_byte)) begin
            pos_reg   <= '0;
            decl_reg  <= '0;
            proto_reg <= 1'b0;
            saddr_reg <= 1'b1;
            dport_reg <= 1'b1;
            sport_reg <= 1'b1;
        end else if (consume) begin
            pos_reg   <= pos_next;
            decl_reg  <= decl_next;
            proto_reg <= proto_next;
            saddr_reg <= saddr_next;
            dport_reg <= dport_next;
            sport_reg <= sport_next;
        end
    end

`include "ipv4_udp_receive_filter_assert.svh"

    `IURF_ASSERT(a_last_clears_count, aclk, aresetn, consume && last_byte |=> pos_reg == 16'd0, "byte count not cleared after last beat")
    `IURF_ASSERT(a_count_advances, aclk, aresetn, consume && !last_byte && pos_reg != BYTE_COUNT_MAX |=> pos_reg == $past(pos_reg) + 16'd1, "byte count did not advance")

endmodule

`default_nettype wire

[rtl/core/iurf_verdict.sv]
// Frame verdict and result output register.
`default_nettype none

module iurf_verdict
    import iurf_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           frame_done,
    input  wire frame_status_t  status,
    input  wire logic           m_tready,
    output logic                m_tvalid,
    output filter_result_t      m_result
);

    reject_code_t   code;
    filter_result_t result_next;
    logic           out_valid_reg;
    filter_result_t result_reg;

    // First failing check wins
    always_comb begin
        if (status.frame_length < HEADER_BYTES) begin
            code = RC_SHORT;
        end else if (!status.proto_ok) begin
            code = RC_NOT_UDP;
        end else if (!status.src_addr_ok) begin
            code = RC_SRC_ADDR;
        end else if (status.declared_length > status.frame_length) begin
            code = RC_LENGTH;
        end else if (!status.dst_port_ok) begin
            code = RC_DST_PORT;
        end else if (!status.src_port_ok) begin
            code = RC_SRC_PORT;
        end else begin
            code = RC_OK;
        end
        result_next.reject_code    = code;
        result_next.accepted       = (code == RC_OK);
        result_next.payload_length = (code == RC_OK) ? status.frame_length - HEADER_BYTES
                                                     : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (frame_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = result_reg;

`include "ipv4_udp_receive_filter_assert.svh"

    `IURF_ASSERT(a_no_overwrite, aclk, aresetn, frame_done |-> !out_valid_reg || m_tready, "result overwritten before it was taken")
    `IURF_ASSERT(a_reject_zero_len, aclk, aresetn, out_valid_reg && !result_reg.accepted |-> result_reg.payload_length == 16'd0, "rejected frame carries a payload length")
    `IURF_ASSERT(a_short_code, aclk, aresetn, frame_done && status.frame_length < HEADER_BYTES |=> result_reg.reject_code == RC_SHORT, "short frame not flagged")

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the IPv4/UDP receive header filter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iurf_pkg::*;

    localparam int          IDLE_PERCENT   = 11;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RESULT_LATENCY = 2;
    localparam int          RANDOM_BYTES   = 1750;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          PRINT_LIMIT    = 40;
    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'h0;

    ipv4_udp_receive_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Register values the stimulus builds frames against
    filter_cfg_t    want_cfg = '{SRC_ADDR_RESET, SRC_PORT_RESET, DST_PORT_RESET};
    // Predictor copy of the registers, updated on each accepted write beat
    filter_cfg_t    shadow_cfg;
    // Predictor copy of the per-frame header state
    logic [15:0]    rx_count;
    logic [15:0]    rx_declared;
    logic           rx_proto_ok;
    logic           rx_addr_ok;
    logic           rx_dport_ok;
    logic           rx_sport_ok;
    filter_result_t pending_verdicts[$];

    logic [7:0]     frame_buf[$];
    bit             steady = 1'b0;
    int unsigned    holds_requested = 0;
    int unsigned    holds_served = 0;
    int             hold_left = 0;
    int unsigned    mismatches = 0;
    int unsigned    cycle_count = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_frame_state();
        rx_count    = 16'd0;
        rx_declared = 16'd0;
        rx_proto_ok = 1'b0;
        rx_addr_ok  = 1'b1;
        rx_dport_ok = 1'b1;
        rx_sport_ok = 1'b1;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        logic [15:0]    pos;
        logic [15:0]    len;
        reject_code_t   code;
        filter_result_t verdict;
        pos = rx_count;
        // Each header byte is compared with the register value of this moment
        case (pos)
            POS_TOTLEN_HI:   rx_declared = {b, 8'h00};
            POS_TOTLEN_LO:   rx_declared = rx_declared | {8'h00, b};
            POS_PROTOCOL:    rx_proto_ok = (b == PROTO_UDP);
            POS_SRC_ADDR0:   if (b != shadow_cfg.src_addr[31:24]) rx_addr_ok = 1'b0;
            POS_SRC_ADDR1:   if (b != shadow_cfg.src_addr[23:16]) rx_addr_ok = 1'b0;
            POS_SRC_ADDR2:   if (b != shadow_cfg.src_addr[15:8])  rx_addr_ok = 1'b0;
            POS_SRC_ADDR3:   if (b != shadow_cfg.src_addr[7:0])   rx_addr_ok = 1'b0;
            POS_SRC_PORT_HI: if (b != shadow_cfg.src_port[15:8])  rx_sport_ok = 1'b0;
            POS_SRC_PORT_LO: if (b != shadow_cfg.src_port[7:0])   rx_sport_ok = 1'b0;
            POS_DST_PORT_HI: if (b != shadow_cfg.dst_port[15:8])  rx_dport_ok = 1'b0;
            POS_DST_PORT_LO: if (b != shadow_cfg.dst_port[7:0])   rx_dport_ok = 1'b0;
            default: ;
        endcase
        // Byte count saturates; an oversize frame counts as 65535 bytes
        len = (pos < BYTE_COUNT_MAX) ? pos + 16'd1 : BYTE_COUNT_MAX;
        rx_count = len;
        if (last) begin
            // First failing check wins
            if (len < HEADER_BYTES)        code = RC_SHORT;
            else if (!rx_proto_ok)         code = RC_NOT_UDP;
            else if (!rx_addr_ok)          code = RC_SRC_ADDR;
            else if (rx_declared > len)    code = RC_LENGTH;
            else if (!rx_dport_ok)         code = RC_DST_PORT;
            else if (!rx_sport_ok)         code = RC_SRC_PORT;
            else                           code = RC_OK;
            verdict.accepted       = (code == RC_OK);
            verdict.payload_length = (code == RC_OK) ? len - HEADER_BYTES : 16'd0;
            verdict.reject_code    = code;
            pending_verdicts.push_back(verdict);
            clear_frame_state();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    // Check result beats first, then fold in this edge's register and byte beats;
    // a byte accepted at this edge cannot own a result seen at the same edge.
    always @(posedge aclk) begin
        filter_result_t seen;
        filter_result_t due;
        if (!aresetn) begin
            shadow_cfg = '{SRC_ADDR_RESET, SRC_PORT_RESET, DST_PORT_RESET};
            clear_frame_state();
            pending_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = filter_result_t'(m_tdata[19:0]);
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch("unexpected result beat", {8'h00, m_tdata}, 32'h0);
                end else begin
                    due = pending_verdicts.pop_front();
                    if (seen.accepted !== due.accepted)
                        flag_mismatch("accepted", 32'(seen.accepted),
                                      32'(due.accepted));
                    if (seen.payload_length !== due.payload_length)
                        flag_mismatch("payload_length", 32'(seen.payload_length),
                                      32'(due.payload_length));
                    if (seen.reject_code !== due.reject_code)
                        flag_mismatch("reject_code", 32'(seen.reject_code),
                                      32'(due.reject_code));
                    if (m_tdata[23:20] !== 4'h0)
                        flag_mismatch("tdata pad bits", 32'(m_tdata[23:20]), 32'h0);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SRC_ADDR: shadow_cfg.src_addr = cfg_data;
                    CFG_SRC_PORT: shadow_cfg.src_port = cfg_data[15:0];
                    CFG_DST_PORT: shadow_cfg.dst_port = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_frame_byte(s_tdata, s_tlast);
        end
    end

    // Result side: random stalls, steady stretches, and long hold-offs on request
    always @(posedge aclk) begin
        if (holds_served != holds_requested) begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Send frame_buf[first..last_idx]; tlast goes with the final byte of the frame
    task automatic send_range(input int first, input int last_idx);
        for (int i = first; i <= last_idx; i++)
            push_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic send_frame();
        send_range(0, frame_buf.size() - 1);
    endtask

    // Wait until every verdict is back and the pipeline has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        settle();
        case (idx)
            CFG_SRC_ADDR: want_cfg.src_addr = value;
            CFG_SRC_PORT: want_cfg.src_port = value[15:0];
            CFG_DST_PORT: want_cfg.dst_port = value[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Build a well-formed frame against want_cfg with the given IP total length
    task automatic build_frame(input int unsigned payload_len, input logic [15:0] declared);
        int unsigned total;
        total = HEADER_BYTES + payload_len;
        frame_buf = {};
        for (int i = 0; i < total; i++)
            frame_buf.push_back(8'($urandom));
        frame_buf[0]               = 8'h45;
        frame_buf[1]               = 8'h00;
        frame_buf[POS_TOTLEN_HI]   = declared[15:8];
        frame_buf[POS_TOTLEN_LO]   = declared[7:0];
        frame_buf[POS_PROTOCOL]    = PROTO_UDP;
        frame_buf[POS_SRC_ADDR0]   = want_cfg.src_addr[31:24];
        frame_buf[POS_SRC_ADDR1]   = want_cfg.src_addr[23:16];
        frame_buf[POS_SRC_ADDR2]   = want_cfg.src_addr[15:8];
        frame_buf[POS_SRC_ADDR3]   = want_cfg.src_addr[7:0];
        frame_buf[POS_SRC_PORT_HI] = want_cfg.src_port[15:8];
        frame_buf[POS_SRC_PORT_LO] = want_cfg.src_port[7:0];
        frame_buf[POS_DST_PORT_HI] = want_cfg.dst_port[15:8];
        frame_buf[POS_DST_PORT_LO] = want_cfg.dst_port[7:0];
        frame_buf[24]              = 8'((total - 20) >> 8);
        frame_buf[25]              = 8'(total - 20);
    endtask

    task automatic flip_byte(input int pos);
        frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(255, 1));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_registers();
        // Frames built for 127.0.0.1, source port 9090, destination port 0
        build_frame(0, 16'd28);
        send_frame();
        build_frame(5, 16'd33);
        send_frame();
    endtask

    task automatic test_check_order();
        // Single byte and one byte short of a full header
        frame_buf = {};
        frame_buf.push_back(8'hFF);
        send_frame();
        build_frame(0, 16'd28);
        void'(frame_buf.pop_back());
        send_frame();
        // Short wins over a bad protocol byte
        build_frame(0, 16'd28);
        frame_buf[POS_PROTOCOL] = PROTO_UDP + 8'd1;
        while (frame_buf.size() > 20) void'(frame_buf.pop_back());
        send_frame();
        build_frame(2, 16'd30);
        frame_buf[POS_PROTOCOL] = PROTO_UDP + 8'd1;
        send_frame();
        for (int k = 0; k < 4; k++) begin
            build_frame(1, 16'd29);
            flip_byte(POS_SRC_ADDR0 + k);
            send_frame();
        end
        // Declared length above, below and at the top of its range
        build_frame(4, 16'd33);
        send_frame();
        build_frame(4, 16'd20);
        send_frame();
        build_frame(1, 16'hFFFF);
        send_frame();
        build_frame(3, 16'd31);
        flip_byte(POS_DST_PORT_HI);
        send_frame();
        build_frame(3, 16'd31);
        flip_byte(POS_DST_PORT_LO);
        send_frame();
        build_frame(3, 16'd31);
        flip_byte(POS_SRC_PORT_HI);
        send_frame();
        build_frame(3, 16'd31);
        flip_byte(POS_SRC_PORT_LO);
        send_frame();
        // Two failures at once: the earlier check must be reported
        build_frame(2, 16'd30);
        frame_buf[POS_PROTOCOL] = 8'h06;
        flip_byte(POS_SRC_ADDR3);
        send_frame();
        build_frame(2, 16'd40);
        flip_byte(POS_SRC_ADDR1);
        send_frame();
        build_frame(2, 16'd40);
        flip_byte(POS_DST_PORT_LO);
        send_frame();
        build_frame(2, 16'd30);
        flip_byte(POS_DST_PORT_HI);
        flip_byte(POS_SRC_PORT_LO);
        send_frame();
    endtask

    task automatic test_register_settings();
        write_reg(CFG_SRC_ADDR, 32'h0000_0000);
        write_reg(CFG_SRC_PORT, 32'h0000_0000);
        write_reg(CFG_DST_PORT, 32'h0000_0000);
        build_frame(3, 16'd31);
        send_frame();
        write_reg(CFG_SRC_ADDR, 32'hFFFF_FFFF);
        write_reg(CFG_SRC_PORT, 32'hFFFF_FFFF);
        write_reg(CFG_DST_PORT, 32'hFFFF_FFFF);
        build_frame(3, 16'd31);
        send_frame();
        build_frame(3, 16'd31);
        frame_buf[POS_DST_PORT_LO] = 8'h00;
        send_frame();
        // Unused index must leave every register alone
        write_reg(CFG_UNUSED, $urandom);
        build_frame(2, 16'd30);
        send_frame();
        write_reg(CFG_SRC_ADDR, $urandom);
        write_reg(CFG_SRC_PORT, $urandom);
        write_reg(CFG_DST_PORT, $urandom);
        build_frame(6, 16'd34);
        send_frame();
    endtask

    task automatic test_midframe_write();
        logic [31:0] new_addr;
        logic [15:0] new_port;
        // Address byte 0 already compared against the old value
        build_frame(4, 16'd32);
        send_range(0, POS_SRC_ADDR0);
        new_addr = {~want_cfg.src_addr[31:24], 24'($urandom)};
        write_reg(CFG_SRC_ADDR, new_addr);
        frame_buf[POS_SRC_ADDR1] = new_addr[23:16];
        frame_buf[POS_SRC_ADDR2] = new_addr[15:8];
        frame_buf[POS_SRC_ADDR3] = new_addr[7:0];
        send_range(POS_SRC_ADDR1, frame_buf.size() - 1);
        // Destination port high byte already past when the port changes
        build_frame(4, 16'd32);
        send_range(0, POS_DST_PORT_HI);
        new_port = {~want_cfg.dst_port[15:8], 8'($urandom)};
        write_reg(CFG_DST_PORT, {16'h0000, new_port});
        frame_buf[POS_DST_PORT_LO] = new_port[7:0];
        send_range(POS_DST_PORT_LO, frame_buf.size() - 1);
    endtask

    task automatic test_oversize_frame();
        // 65540 bytes: count saturates, payload reported as 65507
        build_frame(65512, 16'hFFFF);
        send_frame();
    endtask

    task automatic test_result_stall();
        // Hold the result side while frames keep coming, so the input backs up
        holds_requested++;
        for (int n = 0; n < 16; n++) begin
            build_frame($urandom_range(3), 16'd28);
            send_frame();
        end
        // Pause the sender until every verdict is back
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned budget;
        int unsigned frames;
        int unsigned pick;
        int unsigned payload;
        int unsigned total;
        logic [15:0] declared;
        int          mutate_pos[11] = '{POS_TOTLEN_HI, POS_TOTLEN_LO, POS_PROTOCOL,
                                        POS_SRC_ADDR0, POS_SRC_ADDR1, POS_SRC_ADDR2,
                                        POS_SRC_ADDR3, POS_SRC_PORT_HI, POS_SRC_PORT_LO,
                                        POS_DST_PORT_HI, POS_DST_PORT_LO};
        budget = 0;
        frames = 0;
        steady = 1'b1;
        while (budget < RANDOM_BYTES) begin
            // First quarter runs with no idling on either side
            if (budget > RANDOM_BYTES / 4) steady = 1'b0;
            if (frames % 12 == 11) begin
                case ($urandom_range(2))
                    0: write_reg(cfg_index_t'($urandom_range(CFG_DST_PORT)), 32'h0);
                    1: write_reg(cfg_index_t'($urandom_range(CFG_DST_PORT)), 32'hFFFF_FFFF);
                    default: write_reg(cfg_index_t'($urandom_range(CFG_DST_PORT)), $urandom);
                endcase
            end
            pick    = $urandom_range(99);
            payload = $urandom_range(30);
            total   = HEADER_BYTES + payload;
            case ($urandom_range(9))
                7, 8:    declared = 16'($urandom_range(total));
                9:       declared = 16'(total + $urandom_range(200, 1));
                default: declared = 16'(total);
            endcase
            if (pick < 70) begin
                build_frame(payload, declared);
            end else if (pick < 85) begin
                build_frame(payload, declared);
                flip_byte(mutate_pos[$urandom_range(10)]);
                if ($urandom_range(3) == 0) flip_byte(mutate_pos[$urandom_range(10)]);
            end else begin
                frame_buf = {};
                repeat ($urandom_range(60, 1)) frame_buf.push_back(8'($urandom));
            end
            budget += frame_buf.size();
            send_frame();
            frames++;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_registers();
        test_check_order();
        test_register_settings();
        test_midframe_write();
        test_oversize_frame();
        test_result_stall();
        test_random_traffic();
        settle();
        repeat (RESULT_LATENCY + 4) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
